>>> rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, constants and microcode table of the integer property checker.
// ----------------------------------------------------------------------------
package ipc_pkg;

    // datapath width; the input port keeps its fixed width
    localparam int NUMBER_BITS = 16;
    localparam int INPUT_BITS  = 16;
    localparam int CNT_W       = $clog2(NUMBER_BITS);
    localparam int ZCNT_W      = 3;
    localparam int PC_W        = 4;

    typedef logic [NUMBER_BITS-1:0]   t_num;
    typedef logic [2*NUMBER_BITS-1:0] t_sq;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ZCNT_W-1:0]        t_zcnt;
    typedef logic [PC_W-1:0]          t_pc;

    localparam t_num  RADIX          = t_num'(10);
    localparam t_num  FIRST_DIVISOR  = t_num'(2);
    localparam t_sq   FIRST_SQUARE   = t_sq'(4);
    localparam t_cnt  CNT_LAST       = t_cnt'(NUMBER_BITS - 1);
    localparam t_zcnt ZERO_COUNT_MAX = '1;

    // divide by ten as (x * ceil(2^(w+3) / 10)) >> (w+3), exact for any w-bit x
    localparam int    DIV10_SHIFT    = NUMBER_BITS + 3;
    localparam t_num  DIV10_MUL      = t_num'(((64'd1 << DIV10_SHIFT) + 64'(RADIX) - 64'd1)
                                              / 64'(RADIX));

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_DIV_TRIAL,
        OP_DIV_STEP,
        OP_NEXT_DIV,
        OP_SET_COMP,
        OP_DIG_INIT,
        OP_DIV_TEN,
        OP_DIG_NEXT,
        OP_RESULT,
        OP_REJECT
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_NUM_ZERO,
        C_SQ_GT_NUM,
        C_CNT_NOT_LAST,
        C_REM_ZERO,
        C_DIG_ZERO
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  wait_out;
        t_pc   target;
    } t_uword;

    // status from the datapath
    typedef struct packed {
        logic  num_zero;
        logic  sq_gt_num;
        logic  cnt_last;
        logic  rem_zero;
        logic  dig_zero;
        logic  is_even;
        logic  composite;
        logic  num_ge2;
        t_zcnt zero_count;
    } t_dp_status;

    // everything the sequencer branches on
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic num_zero;
        logic sq_gt_num;
        logic cnt_last;
        logic rem_zero;
        logic dig_zero;
    } t_flags;

    // program addresses
    localparam t_pc S_WAIT      = t_pc'(0);
    localparam t_pc S_CHECK     = t_pc'(1);
    localparam t_pc S_TRIAL     = t_pc'(2);
    localparam t_pc S_TSTART    = t_pc'(3);
    localparam t_pc S_TDIV      = t_pc'(4);
    localparam t_pc S_TTEST     = t_pc'(5);
    localparam t_pc S_TNEXT     = t_pc'(6);
    localparam t_pc S_COMPOSITE = t_pc'(7);
    localparam t_pc S_DIGITS    = t_pc'(8);
    localparam t_pc S_DLOOP     = t_pc'(9);
    localparam t_pc S_DSTART    = t_pc'(10);
    localparam t_pc S_DNEXT     = t_pc'(11);
    localparam t_pc S_RESULT    = t_pc'(12);
    localparam t_pc S_REJECT    = t_pc'(13);

    function automatic t_uword uw(input t_op op, input t_cond cond,
                                  input logic wait_out, input t_pc target);
        t_uword w;
        w.op       = op;
        w.cond     = cond;
        w.wait_out = wait_out;
        w.target   = target;
        return w;
    endfunction

    // microprogram: jump to target when the condition holds, else fall through
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            S_WAIT:      w = uw(OP_WAIT,      C_NO_INPUT,     1'b0, S_WAIT);
            S_CHECK:     w = uw(OP_NOP,       C_NUM_ZERO,     1'b0, S_REJECT);
            S_TRIAL:     w = uw(OP_NOP,       C_SQ_GT_NUM,    1'b0, S_DIGITS);
            S_TSTART:    w = uw(OP_DIV_TRIAL, C_NEVER,        1'b0, S_WAIT);
            S_TDIV:      w = uw(OP_DIV_STEP,  C_CNT_NOT_LAST, 1'b0, S_TDIV);
            S_TTEST:     w = uw(OP_NOP,       C_REM_ZERO,     1'b0, S_COMPOSITE);
            S_TNEXT:     w = uw(OP_NEXT_DIV,  C_ALWAYS,       1'b0, S_TRIAL);
            S_COMPOSITE: w = uw(OP_SET_COMP,  C_NEVER,        1'b0, S_WAIT);
            S_DIGITS:    w = uw(OP_DIG_INIT,  C_NEVER,        1'b0, S_WAIT);
            S_DLOOP:     w = uw(OP_NOP,       C_DIG_ZERO,     1'b0, S_RESULT);
            S_DSTART:    w = uw(OP_DIV_TEN,   C_NEVER,        1'b0, S_WAIT);
            S_DNEXT:     w = uw(OP_DIG_NEXT,  C_ALWAYS,       1'b0, S_DLOOP);
            S_RESULT:    w = uw(OP_RESULT,    C_ALWAYS,       1'b1, S_WAIT);
            S_REJECT:    w = uw(OP_REJECT,    C_ALWAYS,       1'b1, S_WAIT);
            default:     w = uw(OP_NOP,       C_ALWAYS,       1'b0, S_WAIT);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/integer_property_checker_unit.sv
// ----------------------------------------------------------------------------
// integer_property_checker_unit
// Parity, zero decimal digit count and trial-division primality of a number.
// ----------------------------------------------------------------------------
// latency: a zero input goes straight from the check step to the reject step;
//   otherwise it grows with each trial divisor and each decimal digit, set
//   by the one-bit-per-cycle trial divider
// throughput: one transaction at a time; a new number is taken while the
//   previous result still waits in the output register
// reset: synchronous active low, step counter to the idle step, output empty
module integer_property_checker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ipc_pkg::INPUT_BITS-1:0] i_number,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_is_even,
    output logic [ipc_pkg::ZCNT_W-1:0]     o_zero_digits,
    output logic                           o_is_prime,
    output logic                           o_rejected
);

    ipc_pkg::t_op        w_op;
    ipc_pkg::t_flags     w_flags;
    ipc_pkg::t_dp_status w_status;

    logic           r_out_valid;
    logic           r_is_even;
    ipc_pkg::t_zcnt r_zero_digits;
    logic           r_is_prime;
    logic           r_rejected;

    ipc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op)
    );

    ipc_datapath u_dp (
        .i_clk    (i_clk),
        .i_op     (w_op),
        .i_valid  (i_valid),
        .i_number (i_number),
        .o_status (w_status)
    );

    always_comb begin
        w_flags.in_valid  = i_valid;
        w_flags.out_busy  = r_out_valid & ~i_ready;
        w_flags.num_zero  = w_status.num_zero;
        w_flags.sq_gt_num = w_status.sq_gt_num;
        w_flags.cnt_last  = w_status.cnt_last;
        w_flags.rem_zero  = w_status.rem_zero;
        w_flags.dig_zero  = w_status.dig_zero;
    end

    assign o_ready = (w_op == ipc_pkg::OP_WAIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_op == ipc_pkg::OP_RESULT || w_op == ipc_pkg::OP_REJECT) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op == ipc_pkg::OP_RESULT) begin
            r_is_even     <= w_status.is_even;
            r_zero_digits <= w_status.zero_count;
            r_is_prime    <= w_status.num_ge2 & ~w_status.composite;
            r_rejected    <= 1'b0;
        end else if (w_op == ipc_pkg::OP_REJECT) begin
            r_is_even     <= 1'b0;
            r_zero_digits <= '0;
            r_is_prime    <= 1'b0;
            r_rejected    <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_even     = r_is_even;
    assign o_zero_digits = r_zero_digits;
    assign o_is_prime    = r_is_prime;
    assign o_rejected    = r_rejected;

    // a rejected transaction carries no other information
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> !o_is_even && o_zero_digits == '0 && !o_is_prime)
        else $error("rejected result with nonzero fields");

    // the sequencer leaves the idle step right after taking a number
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted twice in a row");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_is_prime) && $stable(o_rejected))
        else $error("pending result overwritten");

endmodule

>>> rtl/ipc_sequencer.sv
// ----------------------------------------------------------------------------
// ipc_sequencer
// Step counter and microcode table; issues one datapath operation per cycle, a no-op while a result step stalls.
// ----------------------------------------------------------------------------
module ipc_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ipc_pkg::t_flags i_flags,
    output ipc_pkg::t_op    o_op
);

    ipc_pkg::t_pc    r_pc;
    ipc_pkg::t_pc    n_pc;
    ipc_pkg::t_uword w_uword;
    logic            w_jump;
    logic            w_hold;

    always_comb begin
        w_uword = ipc_pkg::ucode(r_pc);
        unique case (w_uword.cond)
            ipc_pkg::C_NEVER:        w_jump = 1'b0;
            ipc_pkg::C_ALWAYS:       w_jump = 1'b1;
            ipc_pkg::C_NO_INPUT:     w_jump = ~i_flags.in_valid;
            ipc_pkg::C_NUM_ZERO:     w_jump = i_flags.num_zero;
            ipc_pkg::C_SQ_GT_NUM:    w_jump = i_flags.sq_gt_num;
            ipc_pkg::C_CNT_NOT_LAST: w_jump = ~i_flags.cnt_last;
            ipc_pkg::C_REM_ZERO:     w_jump = i_flags.rem_zero;
            ipc_pkg::C_DIG_ZERO:     w_jump = i_flags.dig_zero;
            default:                 w_jump = 1'b0;
        endcase
        // result steps stall while the output register is still occupied
        w_hold = w_uword.wait_out & i_flags.out_busy;
    end

    always_comb begin
        if (w_hold) begin
            n_pc = r_pc;
            o_op = ipc_pkg::OP_NOP;
        end else begin
            n_pc = w_jump ? w_uword.target : r_pc + ipc_pkg::t_pc'(1);
            o_op = w_uword.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ipc_pkg::S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> rtl/ipc_datapath.sv
// ----------------------------------------------------------------------------
// ipc_datapath
// Number, trial divisor and its square, digit value, a restoring divider
// for the trial divisions that produces one quotient bit per cycle, and a
// reciprocal multiply for the divide by ten of the digit loop.
// ----------------------------------------------------------------------------
module ipc_datapath (
    input  logic                         i_clk,
    input  ipc_pkg::t_op                 i_op,
    input  logic                         i_valid,
    input  logic [ipc_pkg::INPUT_BITS-1:0] i_number,
    output ipc_pkg::t_dp_status          o_status
);

    localparam int W = ipc_pkg::NUMBER_BITS;

    ipc_pkg::t_num  r_num;
    ipc_pkg::t_num  r_div;
    ipc_pkg::t_sq   r_sq;
    ipc_pkg::t_num  r_quo;
    ipc_pkg::t_num  r_dsr;
    ipc_pkg::t_num  r_rem;
    ipc_pkg::t_cnt  r_cnt;
    ipc_pkg::t_num  r_dig;
    ipc_pkg::t_zcnt r_zero;
    logic           r_comp;

    logic [W:0]     w_shift;
    logic [W:0]     w_diff;
    logic           w_ge;
    ipc_pkg::t_num  w_rem_next;
    ipc_pkg::t_sq   w_dig_prod;
    ipc_pkg::t_num  w_dig_quo;
    ipc_pkg::t_num  w_quo_back;

    // one restoring division step
    always_comb begin
        w_shift    = {r_rem, r_quo[W-1]};
        w_ge       = w_shift >= {1'b0, r_dsr};
        w_diff     = w_shift - {1'b0, r_dsr};
        w_rem_next = w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
    end

    // digit divided by ten, and the quotient scaled back to spot a zero digit
    always_comb begin
        w_dig_prod = ipc_pkg::t_sq'(r_dig) * ipc_pkg::t_sq'(ipc_pkg::DIV10_MUL);
        w_dig_quo  = ipc_pkg::t_num'(w_dig_prod >> ipc_pkg::DIV10_SHIFT);
        w_quo_back = r_quo * ipc_pkg::RADIX;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            ipc_pkg::OP_WAIT: begin
                if (i_valid) begin
                    r_num  <= ipc_pkg::t_num'(i_number);
                    r_div  <= ipc_pkg::FIRST_DIVISOR;
                    r_sq   <= ipc_pkg::FIRST_SQUARE;
                    r_comp <= 1'b0;
                    r_zero <= '0;
                end
            end
            ipc_pkg::OP_DIV_TRIAL: begin
                r_quo <= r_num;
                r_dsr <= r_div;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ipc_pkg::OP_DIV_TEN: begin
                r_quo <= w_dig_quo;
            end
            ipc_pkg::OP_DIV_STEP: begin
                r_rem <= w_rem_next;
                r_quo <= {r_quo[W-2:0], w_ge};
                r_cnt <= r_cnt + ipc_pkg::t_cnt'(1);
            end
            ipc_pkg::OP_NEXT_DIV: begin
                // (d+1)^2 = d^2 + 2d + 1
                r_sq  <= r_sq + ipc_pkg::t_sq'({r_div, 1'b1});
                r_div <= r_div + ipc_pkg::t_num'(1);
            end
            ipc_pkg::OP_SET_COMP: begin
                r_comp <= 1'b1;
            end
            ipc_pkg::OP_DIG_INIT: begin
                r_dig <= r_num;
            end
            ipc_pkg::OP_DIG_NEXT: begin
                r_dig <= r_quo;
                if (w_quo_back == r_dig && r_zero != ipc_pkg::ZERO_COUNT_MAX) begin
                    r_zero <= r_zero + ipc_pkg::t_zcnt'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.num_zero   = (r_num == '0);
        o_status.sq_gt_num  = (r_sq > ipc_pkg::t_sq'(r_num));
        o_status.cnt_last   = (r_cnt == ipc_pkg::CNT_LAST);
        o_status.rem_zero   = (r_rem == '0);
        o_status.dig_zero   = (r_dig == '0);
        o_status.is_even    = ~r_num[0];
        o_status.composite  = r_comp;
        o_status.num_ge2    = (r_num > ipc_pkg::t_num'(1));
        o_status.zero_count = r_zero;
    end

endmodule
